// ===== sv/mbr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the mask bilinear resampler.
// Depends on nothing; every other file of the block imports it.
package mbr_pkg;

  // Item codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE    = 3'd5;

  typedef struct packed {
    logic [8:0]  source_width;
    logic [8:0]  source_height;
    logic [10:0] grid_size;
    logic [23:0] step_x;
    logic [23:0] step_y;
    logic        alpha_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    source_width:  9'd256,
    source_height: 9'd256,
    grid_size:     11'd1024,
    step_x:        24'd16384,
    step_y:        24'd16384,
    alpha_mode:    1'b0
  };

  // Channel payloads
  typedef struct packed {
    logic               cmd;
    logic [15:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [9:0]         grid_x;
    logic [9:0]         grid_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pixel_value;
    logic               in_range;
    logic [9:0]         echo_x;
    logic [9:0]         echo_y;
  } out_item_t;

  // Source position: 10-bit coordinate times 24-bit step
  localparam int POS_W = 34;

  // Work classes handed from the front to the back
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_QUERY,
    KIND_EMPTY_QUERY
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e        kind;
    logic [15:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [9:0]         grid_x;
    logic [9:0]         grid_y;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
  } qentry_t;

  // Queue between front and back (depth is a power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // Rounding and saturation
  localparam int ALPHA_DEN     = 255;
  localparam int ALPHA_SHIFT   = 8;
  localparam int T_W           = 24;
  localparam int SAT_POS_LIMIT = 32767;
  localparam int SAT_NEG_LIMIT = 32768;
  localparam logic signed [15:0] PIX_MAX = 16'h7fff;
  localparam logic signed [15:0] PIX_MIN = 16'h8000;

endpackage

// ===== sv/mbr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, computes source positions and classifies them.
// Depends on mbr_pkg; feeds mbr_queue.
module mbr_front import mbr_pkg::*; #(
  parameter int MAX_SOURCE_DIM = 256,
  parameter int MAX_GRID_SIZE  = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  input  qstat_t   qstat_i,
  output logic     push_o,
  output qentry_t  push_data_o
);

  localparam int STORE_DEPTH = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
  localparam int GRID_W      = $clog2(MAX_GRID_SIZE + 1);

  logic              a_valid_q;
  in_item_t          a_item_q;
  logic [QCNT_W:0]   occupancy;
  logic              accept;
  logic [GRID_W-1:0] grid_eff;
  logic              in_store;
  logic              in_range;

  // Hold off while the queue could not take the staged item and one more
  assign occupancy = (QCNT_W + 1)'(qstat_i.count) + (QCNT_W + 1)'(a_valid_q);
  assign busy      = occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept    = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= item_i;
    end
  end

  // Classify the staged item
  always_comb begin
    if (32'(cfg_i.grid_size) > 32'(MAX_GRID_SIZE)) begin
      grid_eff = GRID_W'(MAX_GRID_SIZE);
    end else begin
      grid_eff = GRID_W'(cfg_i.grid_size);
    end
    in_store = 32'(a_item_q.sample_index) < 32'(STORE_DEPTH);
    in_range = (cfg_i.source_width != '0) && (cfg_i.source_height != '0) &&
               (32'(a_item_q.grid_x) < 32'(grid_eff)) &&
               (32'(a_item_q.grid_y) < 32'(grid_eff));

    push_data_o.sample_index = a_item_q.sample_index;
    push_data_o.sample_value = a_item_q.sample_value;
    push_data_o.grid_x       = a_item_q.grid_x;
    push_data_o.grid_y       = a_item_q.grid_y;
    push_data_o.pos_x        = POS_W'(a_item_q.grid_x) * POS_W'(cfg_i.step_x);
    push_data_o.pos_y        = POS_W'(a_item_q.grid_y) * POS_W'(cfg_i.step_y);
    if (a_item_q.cmd == CMD_WRITE) begin
      push_data_o.kind = KIND_WRITE;
    end else if (in_range) begin
      push_data_o.kind = KIND_QUERY;
    end else begin
      push_data_o.kind = KIND_EMPTY_QUERY;
    end
  end

  // Drop writes that fall outside the store
  assign push_o = a_valid_q && ((a_item_q.cmd == CMD_QUERY) || in_store);

endmodule

// ===== sv/mbr_queue.sv =====
`timescale 1ns / 1ps
// Small register queue that decouples the front end from the back end.
// Depends on mbr_pkg for the entry and status types.
module mbr_queue import mbr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qentry_t push_data_i,
  input  logic    pop_i,
  output qentry_t head_o,
  output qstat_t  stat_o
);

  qentry_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  // Advance pointers; the depth is a power of two so they wrap by themselves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = entries[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = count_q == '0;
  assign stat_o.full  = count_q == QCNT_W'(QUEUE_DEPTH);

endmodule

// ===== sv/mbr_back.sv =====
`timescale 1ns / 1ps
// Back end: sample store, four-neighbour fetch, weighting, rounding, result.
// Depends on mbr_pkg; drains mbr_queue.
module mbr_back import mbr_pkg::*; #(
  parameter int MAX_SOURCE_DIM = 256,
  parameter int STEP_FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  qstat_t    qstat_i,
  input  qentry_t   head_i,
  output logic      pop_o,
  output logic      result_valid_o,
  output out_item_t result_o
);

  localparam int DEPTH  = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_SOURCE_DIM);
  localparam int DIM_W  = $clog2(MAX_SOURCE_DIM + 1);
  localparam int WB     = (STEP_FRAC_BITS > 16) ? 16 : STEP_FRAC_BITS;
  localparam int WSHIFT = STEP_FRAC_BITS - WB;
  localparam int R_W    = 17 + WB;
  localparam int ACC_W  = 18 + 2 * WB;
  localparam int MAG_W  = ACC_W;
  localparam int N_W    = MAG_W + 9;
  localparam int ONE_W  = 1 << WB;
  localparam logic [N_W-1:0] PLAIN_HALF = N_W'(1) << (2 * WB - 1);
  localparam logic [N_W-1:0] ALPHA_HALF = N_W'(ALPHA_DEN) << (2 * WB - 1);
  // ceil(2^32 / 255); exact quotient for every numerator below 2^24
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = T_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_255 = 25'h1010102;

  typedef enum logic [3:0] {
    S_IDLE, S_AXIS, S_ROW, S_RD00, S_RD01, S_MIX0, S_ACC0, S_RD10,
    S_RD11, S_MIX1, S_ACC1, S_ABS, S_ROUND, S_DIV, S_SAT
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [WB-1:0]    frac;
  } axis_t;

  // Neighbours and weight of one axis
  function automatic axis_t calc_axis(input logic [POS_W-1:0] pos,
                                      input logic [DIM_W-1:0] dim);
    logic [POS_W-1:0] base;
    logic [DIM_W-1:0] last;
    logic [IDX_W-1:0] lo;
    logic [DIM_W-1:0] nxt;
    axis_t            res;
    base = pos >> STEP_FRAC_BITS;
    last = dim - DIM_W'(1);
    if (base > POS_W'(last)) begin
      lo = IDX_W'(last);
    end else begin
      lo = IDX_W'(base);
    end
    nxt      = DIM_W'(lo) + DIM_W'(1);
    res.lo   = lo;
    res.hi   = (nxt > last) ? IDX_W'(last) : IDX_W'(nxt);
    res.frac = pos[WSHIFT +: WB];
    return res;
  endfunction

  state_e                   state_q, state_d;
  logic                     valid_q, valid_d;
  out_item_t                result_q, result_d;

  logic [POS_W-1:0]         pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [9:0]               echo_x_q, echo_x_d, echo_y_q, echo_y_d;
  logic [IDX_W-1:0]         x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [WB-1:0]            fx_q, fx_d, fy_q, fy_d;
  logic [ADDR_W-1:0]        row_q, row_d;
  logic signed [R_W-1:0]    r_q, r_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     neg_q, neg_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic [T_W-1:0]           t_q, t_d;

  logic [DIM_W-1:0]         w_eff, h_eff;
  logic [WB:0]              bx, by;
  axis_t                    axis_x, axis_y;
  logic [N_W-1:0]           n_plain, n_alpha;
  logic [PROD_W-1:0]        t_scaled;
  logic signed [15:0]       pix;

  logic [15:0]              mem [DEPTH];
  logic [15:0]              rdata_q;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [15:0]              mem_wdata;

  // Clamp the mask size to the store
  always_comb begin
    if (32'(cfg_i.source_width) > 32'(MAX_SOURCE_DIM)) begin
      w_eff = DIM_W'(MAX_SOURCE_DIM);
    end else begin
      w_eff = DIM_W'(cfg_i.source_width);
    end
    if (32'(cfg_i.source_height) > 32'(MAX_SOURCE_DIM)) begin
      h_eff = DIM_W'(MAX_SOURCE_DIM);
    end else begin
      h_eff = DIM_W'(cfg_i.source_height);
    end
  end

  assign bx       = (WB + 1)'(ONE_W) - {1'b0, fx_q};
  assign by       = (WB + 1)'(ONE_W) - {1'b0, fy_q};
  assign axis_x   = calc_axis(pos_x_q, w_eff);
  assign axis_y   = calc_axis(pos_y_q, h_eff);
  assign n_plain  = N_W'(mag_q) + PLAIN_HALF;
  assign n_alpha  = (N_W'(mag_q) << ALPHA_SHIFT) + ALPHA_HALF;
  assign t_scaled = PROD_W'(t_q) * PROD_W'(RECIP_255);

  // Store ports: writes come straight from the queue head
  assign mem_waddr = ADDR_W'(head_i.sample_index);
  assign mem_wdata = head_i.sample_value;
  assign mem_raddr = row_q + ADDR_W'(((state_q == S_RD01) || (state_q == S_RD11)) ?
                                     x1_q : x0_q);

  // Saturate the rounded magnitude
  always_comb begin
    if (neg_q) begin
      pix = (t_q > T_W'(SAT_NEG_LIMIT)) ? PIX_MIN : 16'(T_W'(0) - t_q);
    end else begin
      pix = (t_q > T_W'(SAT_POS_LIMIT)) ? PIX_MAX : 16'(t_q);
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    valid_d  = 1'b0;
    result_d = result_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    echo_x_d = echo_x_q;
    echo_y_d = echo_y_q;
    x0_d     = x0_q;
    x1_d     = x1_q;
    y0_d     = y0_q;
    y1_d     = y1_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    row_d    = row_q;
    r_d      = r_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    t_d      = t_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          case (head_i.kind)
            KIND_WRITE: begin
              mem_we = 1'b1;
            end
            KIND_EMPTY_QUERY: begin
              valid_d              = 1'b1;
              result_d.pixel_value = '0;
              result_d.in_range    = 1'b0;
              result_d.echo_x      = head_i.grid_x;
              result_d.echo_y      = head_i.grid_y;
            end
            KIND_QUERY: begin
              pos_x_d  = head_i.pos_x;
              pos_y_d  = head_i.pos_y;
              echo_x_d = head_i.grid_x;
              echo_y_d = head_i.grid_y;
              state_d  = S_AXIS;
            end
            default: begin
            end
          endcase
        end
      end
      S_AXIS: begin
        x0_d    = axis_x.lo;
        x1_d    = axis_x.hi;
        fx_d    = axis_x.frac;
        y0_d    = axis_y.lo;
        y1_d    = axis_y.hi;
        fy_d    = axis_y.frac;
        state_d = S_ROW;
      end
      S_ROW: begin
        row_d   = ADDR_W'(y0_q) * ADDR_W'(w_eff);
        state_d = S_RD00;
      end
      S_RD00: begin
        state_d = S_RD01;
      end
      S_RD01: begin
        r_d     = R_W'($signed(rdata_q)) * R_W'($signed({1'b0, bx}));
        row_d   = ADDR_W'(y1_q) * ADDR_W'(w_eff);
        state_d = S_MIX0;
      end
      S_MIX0: begin
        r_d     = r_q + R_W'($signed(rdata_q)) * R_W'($signed({1'b0, fx_q}));
        state_d = S_ACC0;
      end
      S_ACC0: begin
        acc_d   = ACC_W'(r_q) * ACC_W'($signed({1'b0, by}));
        state_d = S_RD10;
      end
      S_RD10: begin
        state_d = S_RD11;
      end
      S_RD11: begin
        r_d     = R_W'($signed(rdata_q)) * R_W'($signed({1'b0, bx}));
        state_d = S_MIX1;
      end
      S_MIX1: begin
        r_d     = r_q + R_W'($signed(rdata_q)) * R_W'($signed({1'b0, fx_q}));
        state_d = S_ACC1;
      end
      S_ACC1: begin
        acc_d   = acc_q + ACC_W'(r_q) * ACC_W'($signed({1'b0, fy_q}));
        state_d = S_ABS;
      end
      S_ABS: begin
        neg_d   = acc_q[ACC_W-1];
        mag_d   = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
        state_d = S_ROUND;
      end
      S_ROUND: begin
        if (cfg_i.alpha_mode) begin
          t_d     = T_W'(n_alpha >> (2 * WB));
          state_d = S_DIV;
        end else begin
          t_d     = T_W'(n_plain >> (2 * WB));
          state_d = S_SAT;
        end
      end
      S_DIV: begin
        // Divide by 255 through the reciprocal multiply
        t_d     = T_W'(t_scaled >> RECIP_SHIFT);
        state_d = S_SAT;
      end
      S_SAT: begin
        valid_d              = 1'b1;
        result_d.pixel_value = pix;
        result_d.in_range    = 1'b1;
        result_d.echo_x      = echo_x_q;
        result_d.echo_y      = echo_y_q;
        state_d              = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      result_q <= result_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_x_q  <= pos_x_d;
    pos_y_q  <= pos_y_d;
    echo_x_q <= echo_x_d;
    echo_y_q <= echo_y_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y0_q     <= y0_d;
    y1_q     <= y1_d;
    fx_q     <= fx_d;
    fy_q     <= fy_d;
    row_q    <= row_d;
    r_q      <= r_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    t_q      <= t_d;
  end

  // Sample store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

// ===== sv/mask_bilinear_resampler.sv =====
`timescale 1ns / 1ps
// Top level of the mask bilinear resampler: configuration registers,
// front end, queue and back end. Depends on mbr_pkg and the mbr_* modules.
//
// Usage
//   Items enter on start/item_i and are taken at an edge where busy is low.
//   cmd WRITE stores one mask sample; cmd QUERY asks for one output pixel.
//   Each query yields exactly one result on result_o, shown for a single
//   cycle with result_valid_o high; the receiver cannot stall it, so it must
//   capture the result in that cycle. Writes yield no result.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_wdata_i while
//   the block is idle; there is no read-back.
// Timing
//   The front end stages an item in a register and pushes it into a
//   four-entry queue, so start is taken while the back end still works.
//   The back end sequencer sets the rate: a write or an out-of-range query
//   is handled in S_IDLE alone; an in-range logit query steps through
//   S_AXIS, S_ROW, the reads, mixes and accumulations of both rows, S_ABS,
//   S_ROUND and S_SAT before the next entry is popped, and an alpha query
//   also passes S_DIV, the reciprocal multiply that divides by 255. The
//   four neighbours come from the single read port of the sample store.
// Reset
//   Configuration registers return to their defaults and the queue empties. The store is
//   not cleared: samples must be written before a query reads them.
module mask_bilinear_resampler import mbr_pkg::*; #(
  parameter int MAX_SOURCE_DIM = 256,
  parameter int MAX_GRID_SIZE  = 1024,
  parameter int STEP_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item_i,
  output logic                  result_valid_o,
  output out_item_t             result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  logic    push;
  logic    pop;
  qentry_t push_data;
  qentry_t head;
  qstat_t  qstat;

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_wdata_i[8:0];
        REG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_wdata_i[8:0];
        REG_GRID_SIZE:     cfg_q.grid_size     <= cfg_wdata_i[10:0];
        REG_STEP_X:        cfg_q.step_x        <= cfg_wdata_i[23:0];
        REG_STEP_Y:        cfg_q.step_y        <= cfg_wdata_i[23:0];
        REG_ALPHA_MODE:    cfg_q.alpha_mode    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  mbr_front #(
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM),
    .MAX_GRID_SIZE (MAX_GRID_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  mbr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  mbr_back #(
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM),
    .STEP_FRAC_BITS(STEP_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .qstat_i       (qstat),
    .head_i        (head),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // The front never pushes into a full queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into full queue");

  // The back never pops an empty queue
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // A full queue always holds off new items
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> busy)
    else $error("full queue without busy");

  // An accepted query reaches the queue in the next cycle
  a_query_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.cmd == CMD_QUERY)) |=> push)
    else $error("accepted query not pushed");

endmodule
